FILE: hdl/assert_macros.svh
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define NPA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define NPA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hdl/npa_pkg.sv
package npa_pkg;

	localparam int unsigned POOL_SIZE_DEF = 1024;
	localparam logic [15:0] MIN_PORT_RST = 16'd49152;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_MIN_PORT = '0;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_POOL_EMPTY = 2'd2;

	typedef struct packed {
		logic init_wr;
		logic capture;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: hdl/npa_datapath.sv
module npa_datapath #(
	parameter int unsigned POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  npa_pkg::cmd_t      cmd,
	output npa_pkg::sts_t      sts,
	input  logic [15:0]        min_port,
	input  logic [1:0]         req_type,
	input  logic [15:0]        port_number,
	input  logic [31:0]        client_address,
	input  logic [15:0]        client_port_in,
	input  logic [15:0]        random_draw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [15:0]        granted_port,
	output logic [31:0]        mapped_address,
	output logic [15:0]        mapped_client_port,
	output logic [10:0]        ports_free
);

	localparam int unsigned OFF_W = $clog2(POOL_SIZE);
	localparam int unsigned CNT_W = $clog2(POOL_SIZE + 1);
	localparam int unsigned PROD_W = 16 + CNT_W;

	logic [OFF_W-1:0] pool_mem [POOL_SIZE];
	logic             valid_mem [POOL_SIZE];
	logic [47:0]      client_mem [POOL_SIZE];

	logic [OFF_W-1:0] init_cnt_q;
	logic [CNT_W-1:0] free_total_q;
	logic             out_valid_q;

	logic [1:0]       req_q;
	logic [15:0]      port_q;
	logic [31:0]      addr_q;
	logic [15:0]      cport_q;
	logic [OFF_W-1:0] off_q;
	logic             in_range_q;
	logic [OFF_W-1:0] slot_q;
	logic [OFF_W-1:0] last_q;

	logic [OFF_W-1:0] got_q;
	logic [OFF_W-1:0] last_val_q;
	logic             vld_rd_q;
	logic [47:0]      client_rd_q;

	logic [1:0]       status_q;
	logic [15:0]      granted_q;
	logic [31:0]      maddr_q;
	logic [15:0]      mcport_q;
	logic [10:0]      free_out_q;

	logic [15:0]       off16;
	logic [PROD_W-1:0] prod;
	logic [CNT_W-1:0]  last_full;

	logic             known;
	logic             empty;
	logic             full;
	logic             pool_we;
	logic [OFF_W-1:0] pool_wa;
	logic [OFF_W-1:0] pool_wd;
	logic             vld_we;
	logic [OFF_W-1:0] vld_wa;
	logic             vld_wd;
	logic             cl_we;
	logic [CNT_W-1:0] free_d;
	logic [1:0]       status_d;
	logic [15:0]      granted_d;
	logic [31:0]      maddr_d;
	logic [15:0]      mcport_d;

	assign off16 = port_number - min_port;
	assign prod = PROD_W'(random_draw) * PROD_W'(free_total_q);
	assign last_full = free_total_q - CNT_W'(1);

	// transaction capture, slot and offset registered
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			port_q <= port_number;
			addr_q <= client_address;
			cport_q <= client_port_in;
			off_q <= off16[OFF_W-1:0];
			in_range_q <= (off16 < 16'(POOL_SIZE));
			slot_q <= prod[16 +: OFF_W];
			last_q <= last_full[OFF_W-1:0];
		end
	end

	// synchronous reads
	always_ff @(posedge clk) begin
		got_q <= pool_mem[slot_q];
		last_val_q <= pool_mem[last_q];
		vld_rd_q <= valid_mem[off_q];
		client_rd_q <= client_mem[off_q];
	end

	assign known = in_range_q && vld_rd_q;
	assign empty = (free_total_q == '0);
	assign full = (free_total_q >= CNT_W'(POOL_SIZE));

	always_comb begin
		pool_we = 1'b0;
		pool_wa = init_cnt_q;
		pool_wd = init_cnt_q;
		vld_we = 1'b0;
		vld_wa = init_cnt_q;
		vld_wd = 1'b0;
		cl_we = 1'b0;
		free_d = free_total_q;
		status_d = npa_pkg::ST_NOT_FOUND;
		granted_d = port_q;
		maddr_d = '0;
		mcport_d = '0;
		priority if (cmd.init_wr) begin
			pool_we = 1'b1;
			vld_we = 1'b1;
		end else if (req_q == npa_pkg::REQ_ALLOC) begin
			if (empty) begin
				status_d = npa_pkg::ST_POOL_EMPTY;
				granted_d = '0;
			end else begin
				pool_we = cmd.exec;
				pool_wa = slot_q;
				pool_wd = last_val_q;
				vld_we = cmd.exec;
				vld_wa = got_q;
				vld_wd = 1'b1;
				cl_we = cmd.exec;
				free_d = free_total_q - CNT_W'(1);
				status_d = npa_pkg::ST_OK;
				granted_d = min_port + 16'(got_q);
				maddr_d = addr_q;
				mcport_d = cport_q;
			end
		end else if (req_q == npa_pkg::REQ_LOOKUP) begin
			if (known) begin
				status_d = npa_pkg::ST_OK;
				maddr_d = client_rd_q[47:16];
				mcport_d = client_rd_q[15:0];
			end
		end else if (req_q == npa_pkg::REQ_RELEASE) begin
			if (known) begin
				status_d = npa_pkg::ST_OK;
				vld_we = cmd.exec;
				vld_wa = off_q;
				if (!full) begin
					pool_we = cmd.exec;
					pool_wa = free_total_q[OFF_W-1:0];
					pool_wd = off_q;
					free_d = free_total_q + CNT_W'(1);
				end
			end
		end else begin
			status_d = npa_pkg::ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk) begin
		if (pool_we) begin
			pool_mem[pool_wa] <= pool_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_we) begin
			valid_mem[vld_wa] <= vld_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cl_we) begin
			client_mem[got_q] <= {addr_q, cport_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
			free_total_q <= CNT_W'(POOL_SIZE);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				init_cnt_q <= init_cnt_q + OFF_W'(1);
			end
			if (cmd.exec) begin
				free_total_q <= free_d;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			granted_q <= granted_d;
			maddr_q <= maddr_d;
			mcport_q <= mcport_d;
			free_out_q <= 11'(free_d);
		end
	end

	assign sts.init_last = (init_cnt_q == OFF_W'(POOL_SIZE - 1));
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign granted_port = granted_q;
	assign mapped_address = maddr_q;
	assign mapped_client_port = mcport_q;
	assign ports_free = free_out_q;

endmodule

FILE: hdl/npa_ctrl.sv
module npa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  npa_pkg::sts_t sts,
	output npa_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_INIT = 4'b0001,
		S_IDLE = 4'b0010,
		S_READ = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cmd.init_wr = (state_q == S_INIT);
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.exec = (state_q == S_EXEC) && !sts.out_busy;

endmodule

FILE: hdl/nat_port_allocator.sv
// Translated-port allocator: hands out ports base + offset from a pool of POOL_SIZE
// offsets and keeps a translation table from each granted port to a client
// address and client port. A transaction is a lookup, an allocate or a release (a reserved
// kind gives not found), and each gives exactly one result. A transaction passes through
// capture with slot multiply, synchronous read of pool and table, then write-back (held off
// while a stalled result waits), an order set by the read-modify-write of the synchronous pool
// and table memories; one transaction is in flight at a time and the next is accepted once the
// result is in the output register. After reset the block holds in_stall high while it
// initialises the pool and clears the table valid bits, one entry a cycle; the APB register is
// writable throughout.
module nat_port_allocator #(
	parameter int unsigned POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [npa_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic [15:0]                  port_number,
	input  logic [31:0]                  client_address,
	input  logic [15:0]                  client_port_in,
	input  logic [15:0]                  random_draw,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [15:0]                  granted_port,
	output logic [31:0]                  mapped_address,
	output logic [15:0]                  mapped_client_port,
	output logic [10:0]                  ports_free
);

	logic [15:0]   min_port_q;
	logic          reg_sel;
	npa_pkg::cmd_t cmd;
	npa_pkg::sts_t sts;

	assign pready = 1'b1;
	assign reg_sel = (paddr[npa_pkg::PADDR_W-1:2] == npa_pkg::REG_MIN_PORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_port_q <= npa_pkg::MIN_PORT_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			min_port_q <= pwdata[15:0];
		end
	end

	assign prdata = reg_sel ? {16'b0, min_port_q} : 32'b0;

	npa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	npa_datapath #(
		.POOL_SIZE (POOL_SIZE)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.min_port           (min_port_q),
		.req_type           (req_type),
		.port_number        (port_number),
		.client_address     (client_address),
		.client_port_in     (client_port_in),
		.random_draw        (random_draw),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.granted_port       (granted_port),
		.mapped_address     (mapped_address),
		.mapped_client_port (mapped_client_port),
		.ports_free         (ports_free)
	);

endmodule

FILE: hdl/npa_checker.sv
`include "assert_macros.svh"

module npa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] granted_port,
	input logic [31:0] mapped_address,
	input logic [15:0] mapped_client_port,
	input logic [10:0] ports_free
);

	`NPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result lost under stall")

	`NPA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(granted_port) && $stable(mapped_address) && $stable(mapped_client_port) && $stable(ports_free), "result changed under stall")

	`NPA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second transaction taken while busy")

	`NPA_ASSERT(a_empty_result, out_valid && status == npa_pkg::ST_POOL_EMPTY |-> granted_port == 16'd0 && mapped_address == 32'd0 && ports_free == 11'd0, "pool empty result not cleared")

endmodule

bind nat_port_allocator npa_checker u_npa_checker (.*);

FILE: verif/tb.sv
module tb;
	import npa_pkg::*;

	localparam int unsigned POOL = POOL_SIZE_DEF;
	localparam logic [1:0] REQ_RSVD = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_MIN_PORT = {REG_MIN_PORT, 2'b00};
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int QUEUE_AHEAD = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] port;
		logic [31:0] addr;
		logic [15:0] cport;
		logic [15:0] draw;
	} nat_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] port;
		logic [31:0] addr;
		logic [15:0] cport;
		logic [10:0] free;
	} nat_resp_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          req_type = '0;
	logic [15:0]         port_number = '0;
	logic [31:0]         client_address = '0;
	logic [15:0]         client_port_in = '0;
	logic [15:0]         random_draw = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          status;
	logic [15:0]         granted_port;
	logic [31:0]         mapped_address;
	logic [15:0]         mapped_client_port;
	logic [10:0]         ports_free;

	nat_port_allocator dut (.*);

	always #5 clk = ~clk;

	// predicted allocator state
	logic [15:0] base_port;
	logic [15:0] pool_off [POOL];
	int unsigned pool_count;
	logic        map_valid [POOL];
	logic [47:0] map_client [POOL];
	bit          pool_drained;

	nat_req_t  req_pending [$];
	nat_resp_t grant_expected [$];

	int  err_count = 0;
	int  cycle_count = 0;
	int  results_seen = 0;
	bit  in_took = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;
	int  hold_left = 0;
	int  hold_mark = 300;
	int  mode_left = 0;
	int  stall_pct = 0;

	task automatic translate_and_update(input nat_req_t rq);
		nat_resp_t r;
		logic [15:0] off;
		logic [31:0] slot;
		logic [15:0] got;
		bit known;
		off = rq.port - base_port;
		known = (off < POOL) && map_valid[off];
		r = '0;
		r.status = ST_NOT_FOUND;
		r.port = rq.port;
		case (rq.kind)
		REQ_ALLOC: begin
			r.port = '0;
			if (pool_count == 0) begin
				r.status = ST_POOL_EMPTY;
				pool_drained = 1'b1;
			end else begin
				slot = (32'(rq.draw) * pool_count) >> 16;
				got = pool_off[slot];
				pool_off[slot] = pool_off[pool_count-1];
				pool_count--;
				map_valid[got] = 1'b1;
				map_client[got] = {rq.addr, rq.cport};
				r.status = ST_OK;
				r.port = base_port + got;
				r.addr = rq.addr;
				r.cport = rq.cport;
			end
		end
		REQ_LOOKUP: begin
			if (known) begin
				r.status = ST_OK;
				{r.addr, r.cport} = map_client[off];
			end
		end
		REQ_RELEASE: begin
			if (known) begin
				map_valid[off] = 1'b0;
				if (pool_count < POOL) begin
					pool_off[pool_count] = off;
					pool_count++;
				end
				r.status = ST_OK;
			end
		end
		default: ;
		endcase
		r.free = pool_count[10:0];
		grant_expected.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// result checking and prediction on accepted requests
	always @(posedge clk) begin
		nat_resp_t e;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count == CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				if (out_valid && !out_stall) begin
					results_seen++;
					if (grant_expected.size() == 0) begin
						err_count++;
						$display("%0t unexpected transaction: expected none, actual status %0d port %0h",
							$time, status, granted_port);
					end else begin
						e = grant_expected.pop_front();
						check_field("status", e.status, status);
						check_field("granted_port", e.port, granted_port);
						check_field("mapped_address", e.addr, mapped_address);
						check_field("mapped_client_port", e.cport, mapped_client_port);
						check_field("ports_free", e.free, ports_free);
					end
				end
				in_took = in_valid && !in_stall;
				if (in_took)
					translate_and_update({req_type, port_number, client_address,
						client_port_in, random_draw});
			end
		end
	end

	// request driver: bursts with random gaps
	always @(negedge clk) begin
		nat_req_t cur;
		if (!(in_valid && !in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_pending.size() > 0) begin
				cur = req_pending.pop_front();
				req_type <= cur.kind;
				port_number <= cur.port;
				client_address <= cur.addr;
				client_port_in <= cur.cport;
				random_draw <= cur.draw;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(24, 1);
					gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall pattern, with long hold-offs to back the block up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (results_seen >= hold_mark) begin
			hold_left = HOLD_CYCLES;
			hold_mark += 800;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(60, 1);
				case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 25;
				default: stall_pct = 70;
				endcase
			end
			mode_left--;
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic queue_request(input logic [1:0] kind, input logic [15:0] port,
			input logic [31:0] addr, input logic [15:0] cport, input logic [15:0] draw);
		while (req_pending.size() >= QUEUE_AHEAD)
			@(posedge clk);
		req_pending.push_back({kind, port, addr, cport, draw});
	endtask

	function automatic logic [15:0] mapped_port();
		int start;
		start = $urandom_range(POOL - 1);
		for (int k = 0; k < POOL; k++)
			if (map_valid[(start + k) % POOL])
				return base_port + 16'((start + k) % POOL);
		return base_port + 16'(start);
	endfunction

	task automatic random_request(input int pct_alloc, input int pct_release,
			input int pct_lookup);
		nat_req_t rq;
		int r;
		while (req_pending.size() >= QUEUE_AHEAD)
			@(posedge clk);
		rq.port = $urandom;
		rq.addr = $urandom;
		rq.cport = $urandom;
		rq.draw = $urandom;
		r = $urandom_range(99);
		if (r < pct_alloc) begin
			rq.kind = REQ_ALLOC;
			case ($urandom_range(19))
			0: rq.draw = '0;
			1: rq.draw = '1;
			default: ;
			endcase
		end else begin
			if (r < pct_alloc + pct_release)
				rq.kind = REQ_RELEASE;
			else if (r < pct_alloc + pct_release + pct_lookup)
				rq.kind = REQ_LOOKUP;
			else
				rq.kind = REQ_RSVD;
			case ($urandom_range(7))
			0: ;
			1: rq.port = base_port + 16'($urandom_range(POOL));
			default: rq.port = mapped_port();
			endcase
		end
		req_pending.push_back(rq);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (req_pending.size() != 0 || in_valid || grant_expected.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_min_port(input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MIN_PORT;
		pwdata <= {16'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		base_port = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int n;
		int extra;
		for (int i = 0; i < POOL; i++) begin
			pool_off[i] = 16'(i);
			map_valid[i] = 1'b0;
			map_client[i] = '0;
		end
		pool_count = POOL;
		base_port = MIN_PORT_RST;
		pool_drained = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: misses, reserved kind, draw extremes, range edges, double release
		queue_request(REQ_LOOKUP, MIN_PORT_RST, '0, '0, '0);
		queue_request(REQ_RELEASE, MIN_PORT_RST, '0, '0, '0);
		queue_request(REQ_RSVD, 16'hFFFF, '1, '1, '1);
		queue_request(REQ_LOOKUP, 16'h0000, '0, '0, '0);
		queue_request(REQ_ALLOC, 16'h0000, 32'h0, 16'h0, 16'h0000);
		queue_request(REQ_ALLOC, 16'hFFFF, '1, '1, 16'hFFFF);
		queue_request(REQ_LOOKUP, MIN_PORT_RST, '0, '0, '0);
		queue_request(REQ_LOOKUP, MIN_PORT_RST + 16'd1022, '0, '0, '0);
		queue_request(REQ_LOOKUP, MIN_PORT_RST + 16'd1023, '0, '0, '0);
		queue_request(REQ_LOOKUP, MIN_PORT_RST + 16'd1024, '0, '0, '0);
		queue_request(REQ_LOOKUP, MIN_PORT_RST - 16'd1, '0, '0, '0);
		queue_request(REQ_RELEASE, MIN_PORT_RST, '0, '0, '0);
		queue_request(REQ_RELEASE, MIN_PORT_RST, '0, '0, '0);
		queue_request(REQ_LOOKUP, MIN_PORT_RST, '0, '0, '0);
		queue_request(REQ_ALLOC, MIN_PORT_RST, 32'hA5A5_5A5A, 16'h5A5A, 16'h8000);
		queue_request(REQ_RSVD, MIN_PORT_RST + 16'd1022, 32'h1, 16'h1, 16'h1);
		queue_request(REQ_RELEASE, MIN_PORT_RST + 16'd1022, '0, '0, '0);
		queue_request(REQ_ALLOC, 16'h0000, 32'h8000_0001, 16'h8001, 16'h0001);

		// low base, mappings from above carried over
		wait_idle();
		set_min_port(16'd0);
		repeat (60) random_request(50, 25, 20);

		// top base, allocate until the pool runs dry and beyond
		wait_idle();
		set_min_port(16'd64512);
		pool_drained = 1'b0;
		n = 0;
		extra = 0;
		while (!pool_drained || extra < 40) begin
			random_request(88, 6, 4);
			if (pool_drained)
				extra++;
			n++;
			if (n > 4000)
				break;
		end

		// random base, mostly releases
		wait_idle();
		set_min_port(16'($urandom_range(64512)));
		repeat (80) random_request(25, 50, 22);

		wait_idle();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/npa_pkg.sv
hdl/npa_datapath.sv
hdl/npa_ctrl.sv
hdl/nat_port_allocator.sv
hdl/npa_checker.sv
verif/tb.sv
